// ===== design/eig_pkg.sv =====
// eig_pkg: shared widths, payload structs and small helper functions for the
// symmetric 2x2 eigen solver; no dependencies
`default_nettype none

package eig_pkg;

  localparam int DataW    = 32;  // q16.16 entries and eigenvalues
  localparam int DiffW    = 33;  // a + c, a - c
  localparam int RootRadW = 66;  // d*d + 4*b*b
  localparam int RootW    = RootRadW / 2;
  localparam int WideW    = 35;  // s +/- r, -d +/- r
  localparam int UxW      = 33;  // |2b|
  localparam int MagW     = 31;  // component magnitude after pre-shift
  localparam int SqW      = 2 * MagW;
  localparam int NormRadW = 64;  // x*x + y*y, padded to even
  localparam int LenW     = NormRadW / 2;
  localparam int FracBits = 15;
  localparam int QuotW    = FracBits + 2;
  localparam int UnitW    = 16;
  localparam logic [UnitW-1:0] UnitMax = 16'h7FFF;

  typedef struct packed {
    logic [DiffW-1:0] s;
    logic [DiffW-1:0] d;
    logic [DataW-1:0] b;
  } front_pay_t;

  typedef struct packed {
    logic [DataW-1:0] kmin;
    logic [DataW-1:0] kmax;
  } kappa_t;

  typedef struct packed {
    logic            tiny;
    logic            neg_x;
    logic            neg_y;
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
  } vec_side_t;

  typedef struct packed {
    kappa_t    kap;
    vec_side_t side;
  } min_pay_t;

  typedef struct packed {
    kappa_t kap;
    logic   tiny;
    logic   neg;
  } div_xl_pay_t;

  typedef struct packed {
    logic tiny;
    logic neg;
  } div_xh_pay_t;

  // floor(v / 2) saturated to int32
  function automatic logic [DataW-1:0] sat_half(input logic [WideW-1:0] v);
    logic [WideW-2:0] h;
    begin
      h = v[WideW-1:1];
      if (h[WideW-2:DataW-1] == {(WideW-DataW){h[DataW-1]}}) begin
        sat_half = h[DataW-1:0];
      end else if (h[WideW-2]) begin
        sat_half = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        sat_half = {1'b0, {(DataW-1){1'b1}}};
      end
    end
  endfunction

  // right shift that brings the larger magnitude below 2^31
  function automatic logic [2:0] pre_shift(input logic [WideW-1:0] m);
    begin
      if (m[34]) begin
        pre_shift = 3'd4;
      end else if (m[33]) begin
        pre_shift = 3'd3;
      end else if (m[32]) begin
        pre_shift = 3'd2;
      end else if (m[31]) begin
        pre_shift = 3'd1;
      end else begin
        pre_shift = 3'd0;
      end
    end
  endfunction

  // vector no longer than one lsb: x*x + y*y <= 4 on the doubled vector
  function automatic logic is_tiny(input logic [WideW-1:0] ux, input logic [WideW-1:0] uy);
    logic       sx;
    logic       sy;
    logic [4:0] t;
    begin
      sx = (ux[WideW-1:2] == '0) && (ux[1:0] != 2'b11);
      sy = (uy[WideW-1:2] == '0) && (uy[1:0] != 2'b11);
      t = 5'(ux[1:0]) * 5'(ux[1:0]) + 5'(uy[1:0]) * 5'(uy[1:0]);
      is_tiny = sx && sy && (t <= 5'd4);
    end
  endfunction

  // cap quotient to q1.15, apply sign, force zero for a tiny vector
  function automatic logic [UnitW-1:0] unit_out(input logic [QuotW-1:0] q, input logic neg,
                                                input logic tiny);
    logic [UnitW-1:0] m;
    begin
      if (q > QuotW'(UnitMax)) begin
        m = UnitMax;
      end else begin
        m = q[UnitW-1:0];
      end
      if (tiny) begin
        unit_out = '0;
      end else if (neg) begin
        unit_out = UnitW'(0) - m;
      end else begin
        unit_out = m;
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/eig_front.sv =====
// eig_front: first three stages, sum and difference, squares, radicand d*d + 4*b*b
// depends on eig_pkg
`default_nettype none

module eig_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [eig_pkg::DataW-1:0]   a,
  input  logic signed [eig_pkg::DataW-1:0]   b,
  input  logic signed [eig_pkg::DataW-1:0]   c,
  output logic                               out_vld,
  output logic [eig_pkg::RootRadW-1:0]       out_rad,
  output eig_pkg::front_pay_t                out_pay
);

  logic                              v1;
  logic signed [eig_pkg::DiffW-1:0]  s1;
  logic signed [eig_pkg::DiffW-1:0]  d1;
  logic signed [eig_pkg::DataW-1:0]  b1;
  logic                              v2;
  logic [63:0]                       dd2;
  logic [62:0]                       bb2;
  eig_pkg::front_pay_t               p2;
  logic                              v3;
  logic [eig_pkg::RootRadW-1:0]      rad3;
  eig_pkg::front_pay_t               p3;
  logic signed [65:0]                dsq;
  logic signed [63:0]                bsq;

  assign dsq = d1 * d1;
  assign bsq = b1 * b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= {a[eig_pkg::DataW-1], a} + {c[eig_pkg::DataW-1], c};
      d1   <= {a[eig_pkg::DataW-1], a} - {c[eig_pkg::DataW-1], c};
      b1   <= b;
      dd2  <= dsq[63:0];
      bb2  <= bsq[62:0];
      p2   <= '{s: s1, d: d1, b: b1};
      rad3 <= {2'b00, dd2} + {1'b0, bb2, 2'b00};
      p3   <= p2;
    end
  end

  assign out_vld = v3;
  assign out_rad = rad3;
  assign out_pay = p3;

endmodule

`default_nettype wire

// ===== design/eig_sqrt_pipe.sv =====
// eig_sqrt_pipe: floor square root, one result bit per register stage, with a
// payload that travels alongside; depends on eig_pkg
`default_nettype none

module eig_sqrt_pipe #(
  parameter int RW = eig_pkg::RootRadW,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [RW-1:0]   in_rad,
  input  logic [PW-1:0]   in_pay,
  output logic            out_vld,
  output logic [RW/2-1:0] out_root,
  output logic [PW-1:0]   out_pay
);

  localparam int QW = RW / 2;

  logic          vld_q  [QW];
  logic [QW:0]   rem_q  [QW];
  logic [QW-1:0] root_q [QW];
  logic [RW-1:0] rad_q  [QW];
  logic [PW-1:0] pay_q  [QW];

  logic          vld_next  [QW];
  logic [QW:0]   rem_next  [QW];
  logic [QW-1:0] root_next [QW];
  logic [RW-1:0] rad_next  [QW];
  logic [PW-1:0] pay_next  [QW];

  always_comb begin
    logic [QW:0]   rem_i;
    logic [QW-1:0] root_i;
    logic [RW-1:0] rad_i;
    logic [QW+1:0] rem_sh;
    logic [QW+1:0] trial;
    logic [QW+1:0] diff;
    logic          ge;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        rem_i       = '0;
        root_i      = '0;
        rad_i       = in_rad;
        vld_next[j] = in_vld;
        pay_next[j] = in_pay;
      end else begin
        rem_i       = rem_q[j-1];
        root_i      = root_q[j-1];
        rad_i       = rad_q[j-1];
        vld_next[j] = vld_q[j-1];
        pay_next[j] = pay_q[j-1];
      end
      // bring down the next two radicand bits
      rem_sh       = {rem_i[QW-1:0], rad_i[RW-1:RW-2]};
      trial        = {root_i, 2'b01};
      ge           = rem_sh >= trial;
      diff         = rem_sh - trial;
      rem_next[j]  = ge ? diff[QW:0] : rem_sh[QW:0];
      root_next[j] = {root_i[QW-2:0], ge};
      rad_next[j]  = {rad_i[RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < QW; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else if (en) begin
      for (int j = 0; j < QW; j++) begin
        vld_q[j] <= vld_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        rem_q[j]  <= rem_next[j];
        root_q[j] <= root_next[j];
        rad_q[j]  <= rad_next[j];
        pay_q[j]  <= pay_next[j];
      end
    end
  end

  assign out_vld  = vld_q[QW-1];
  assign out_root = root_q[QW-1];
  assign out_pay  = pay_q[QW-1];

endmodule

`default_nettype wire

// ===== design/eig_vprep.sv =====
// eig_vprep: eigenvalues, doubled eigenvectors, pre-shift and squared lengths,
// four register stages; depends on eig_pkg
`default_nettype none

module eig_vprep (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [eig_pkg::RootW-1:0]         root,
  input  eig_pkg::front_pay_t               in_pay,
  output logic                              out_vld,
  output logic [eig_pkg::NormRadW-1:0]      sum_min,
  output logic [eig_pkg::NormRadW-1:0]      sum_max,
  output eig_pkg::kappa_t                   kap,
  output eig_pkg::vec_side_t                side_min,
  output eig_pkg::vec_side_t                side_max
);

  localparam int WW = eig_pkg::WideW;

  logic [WW-1:0] s_x;
  logic [WW-1:0] d_x;
  logic [WW-1:0] r_x;
  logic [WW-1:0] lo;
  logic [WW-1:0] hi;
  logic [WW-1:0] ylo;
  logic [WW-1:0] yhi;
  logic [eig_pkg::DataW-1:0] absb;

  logic                      v1;
  eig_pkg::kappa_t           k1;
  logic [eig_pkg::UxW-1:0]   ux1;
  logic [WW-1:0]             uyl1;
  logic [WW-1:0]             uyh1;
  logic                      nx1;
  logic                      nyl1;
  logic                      nyh1;

  logic [WW-1:0]             ux_x;
  logic [2:0]                shl;
  logic [2:0]                shh;
  logic [WW-1:0]             mxl;
  logic [WW-1:0]             myl;
  logic [WW-1:0]             mxh;
  logic [WW-1:0]             myh;

  logic                      v2;
  eig_pkg::kappa_t           k2;
  eig_pkg::vec_side_t        sl2;
  eig_pkg::vec_side_t        sh2;

  logic                      v3;
  eig_pkg::kappa_t           k3;
  eig_pkg::vec_side_t        sl3;
  eig_pkg::vec_side_t        sh3;
  logic [eig_pkg::SqW-1:0]   sqxl3;
  logic [eig_pkg::SqW-1:0]   sqyl3;
  logic [eig_pkg::SqW-1:0]   sqxh3;
  logic [eig_pkg::SqW-1:0]   sqyh3;

  logic                      v4;
  eig_pkg::kappa_t           k4;
  eig_pkg::vec_side_t        sl4;
  eig_pkg::vec_side_t        sh4;
  logic [eig_pkg::NormRadW-1:0] suml4;
  logic [eig_pkg::NormRadW-1:0] sumh4;

  // stage one: s -/+ r and the y components -d -/+ r
  assign s_x  = {{(WW-eig_pkg::DiffW){in_pay.s[eig_pkg::DiffW-1]}}, in_pay.s};
  assign d_x  = {{(WW-eig_pkg::DiffW){in_pay.d[eig_pkg::DiffW-1]}}, in_pay.d};
  assign r_x  = {{(WW-eig_pkg::RootW){1'b0}}, root};
  assign lo   = s_x - r_x;
  assign hi   = s_x + r_x;
  assign ylo  = WW'(0) - d_x - r_x;
  assign yhi  = r_x - d_x;
  assign absb = in_pay.b[eig_pkg::DataW-1] ? (eig_pkg::DataW'(0) - in_pay.b) : in_pay.b;

  // stage two: shift both magnitudes until the larger fits in 31 bits
  assign ux_x = {{(WW-eig_pkg::UxW){1'b0}}, ux1};
  assign shl  = eig_pkg::pre_shift(ux_x | uyl1);
  assign shh  = eig_pkg::pre_shift(ux_x | uyh1);
  assign mxl  = ux_x >> shl;
  assign myl  = uyl1 >> shl;
  assign mxh  = ux_x >> shh;
  assign myh  = uyh1 >> shh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1   <= '{kmin: eig_pkg::sat_half(lo), kmax: eig_pkg::sat_half(hi)};
      ux1  <= {absb, 1'b0};
      uyl1 <= ylo[WW-1] ? (WW'(0) - ylo) : ylo;
      uyh1 <= yhi[WW-1] ? (WW'(0) - yhi) : yhi;
      nx1  <= in_pay.b[eig_pkg::DataW-1];
      nyl1 <= ylo[WW-1];
      nyh1 <= yhi[WW-1];

      k2  <= k1;
      sl2 <= '{tiny: eig_pkg::is_tiny(ux_x, uyl1), neg_x: nx1, neg_y: nyl1,
               mag_x: mxl[eig_pkg::MagW-1:0], mag_y: myl[eig_pkg::MagW-1:0]};
      sh2 <= '{tiny: eig_pkg::is_tiny(ux_x, uyh1), neg_x: nx1, neg_y: nyh1,
               mag_x: mxh[eig_pkg::MagW-1:0], mag_y: myh[eig_pkg::MagW-1:0]};

      k3    <= k2;
      sl3   <= sl2;
      sh3   <= sh2;
      sqxl3 <= sl2.mag_x * sl2.mag_x;
      sqyl3 <= sl2.mag_y * sl2.mag_y;
      sqxh3 <= sh2.mag_x * sh2.mag_x;
      sqyh3 <= sh2.mag_y * sh2.mag_y;

      k4    <= k3;
      sl4   <= sl3;
      sh4   <= sh3;
      suml4 <= {2'b00, sqxl3} + {2'b00, sqyl3};
      sumh4 <= {2'b00, sqxh3} + {2'b00, sqyh3};
    end
  end

  assign out_vld  = v4;
  assign sum_min  = suml4;
  assign sum_max  = sumh4;
  assign kap      = k4;
  assign side_min = sl4;
  assign side_max = sh4;

endmodule

`default_nettype wire

// ===== design/eig_div_pipe.sv =====
// eig_div_pipe: round(mag * 2^15 / len), one prep stage then one quotient bit
// per register stage; depends on eig_pkg
`default_nettype none

module eig_div_pipe #(
  parameter int MW = eig_pkg::MagW,
  parameter int DW = eig_pkg::LenW,
  parameter int QW = eig_pkg::QuotW,
  parameter int FB = eig_pkg::FracBits,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [MW-1:0] mag,
  input  logic [DW-1:0] len,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [QW-1:0] quot,
  output logic [PW-1:0] out_pay
);

  localparam int NW = DW + QW;

  logic          vp;
  logic [NW-1:0] num_p;
  logic [DW-1:0] den_p;
  logic [PW-1:0] pay_p;

  logic          vld_q [QW];
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] nlo_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [PW-1:0] pay_q [QW];

  logic          vld_next [QW];
  logic [DW-1:0] rem_next [QW];
  logic [QW-1:0] nlo_next [QW];
  logic [QW-1:0] quo_next [QW];
  logic [DW-1:0] den_next [QW];
  logic [PW-1:0] pay_next [QW];

  always_comb begin
    logic [DW-1:0] rem_i;
    logic [QW-1:0] nlo_i;
    logic [QW-1:0] quo_i;
    logic [DW-1:0] den_i;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        // numerator is below len * 2^QW, so the top part starts below len
        rem_i       = num_p[NW-1:QW];
        nlo_i       = num_p[QW-1:0];
        quo_i       = '0;
        den_i       = den_p;
        vld_next[j] = vp;
        pay_next[j] = pay_p;
      end else begin
        rem_i       = rem_q[j-1];
        nlo_i       = nlo_q[j-1];
        quo_i       = quo_q[j-1];
        den_i       = den_q[j-1];
        vld_next[j] = vld_q[j-1];
        pay_next[j] = pay_q[j-1];
      end
      rem_sh      = {rem_i, nlo_i[QW-1]};
      diff        = rem_sh - {1'b0, den_i};
      ge          = rem_sh >= {1'b0, den_i};
      rem_next[j] = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      nlo_next[j] = {nlo_i[QW-2:0], 1'b0};
      quo_next[j] = {quo_i[QW-2:0], ge};
      den_next[j] = den_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
      for (int j = 0; j < QW; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else if (en) begin
      vp <= in_vld;
      for (int j = 0; j < QW; j++) begin
        vld_q[j] <= vld_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // mag * 2^15 + len / 2, with a zero length read as one
      num_p <= NW'({mag, {FB{1'b0}}}) + NW'(len[DW-1:1]);
      den_p <= (len == '0) ? DW'(1) : len;
      pay_p <= in_pay;
      for (int j = 0; j < QW; j++) begin
        rem_q[j] <= rem_next[j];
        nlo_q[j] <= nlo_next[j];
        quo_q[j] <= quo_next[j];
        den_q[j] <= den_next[j];
        pay_q[j] <= pay_next[j];
      end
    end
  end

  assign out_vld = vld_q[QW-1];
  assign quot    = quo_q[QW-1];
  assign out_pay = pay_q[QW-1];

endmodule

`default_nettype wire

// ===== design/symmetric_2x2_eigen_solver.sv =====
// symmetric_2x2_eigen_solver: top level, eigenvalues and unit eigenvectors of [a b; b c]
// depends on eig_pkg, eig_front, eig_sqrt_pipe, eig_vprep, eig_div_pipe
//
//   channel | handshake            | beat
//   --------+----------------------+-------------------------------------------
//   matrix  | mat_valid, mat_stall | diag_a, off_b, diag_c
//   eigen   | eig_valid, eig_stall | kappa_min, kappa_max, vec_min_x/y, vec_max_x/y
//
// one beat per cycle in, one per cycle out unless the output stalls; most stages are in
// the two bit-serial square root pipelines (33 and 32 stages) and the 18 stage dividers
// the whole pipeline advances together; a stalled output beat freezes every stage
// and mat_stall is raised for as long as the output beat waits
// synchronous reset clears all valid bits; no clearing pass is needed
`default_nettype none

module symmetric_2x2_eigen_solver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                mat_valid,
  output logic                                mat_stall,
  input  logic signed [eig_pkg::DataW-1:0]    diag_a,
  input  logic signed [eig_pkg::DataW-1:0]    off_b,
  input  logic signed [eig_pkg::DataW-1:0]    diag_c,
  output logic                                eig_valid,
  input  logic                                eig_stall,
  output logic signed [eig_pkg::DataW-1:0]    kappa_min,
  output logic signed [eig_pkg::DataW-1:0]    kappa_max,
  output logic signed [eig_pkg::UnitW-1:0]    vec_min_x,
  output logic signed [eig_pkg::UnitW-1:0]    vec_min_y,
  output logic signed [eig_pkg::UnitW-1:0]    vec_max_x,
  output logic signed [eig_pkg::UnitW-1:0]    vec_max_y
);

  localparam int MinPW = $bits(eig_pkg::min_pay_t);
  localparam int SidePW = $bits(eig_pkg::vec_side_t);
  localparam int XlPW = $bits(eig_pkg::div_xl_pay_t);
  localparam int XhPW = $bits(eig_pkg::div_xh_pay_t);

  logic                            en;
  logic                            f_vld;
  logic [eig_pkg::RootRadW-1:0]    f_rad;
  eig_pkg::front_pay_t             f_pay;
  logic                            r_vld;
  logic [eig_pkg::RootW-1:0]       r_root;
  logic [$bits(eig_pkg::front_pay_t)-1:0] r_pay_bits;
  eig_pkg::front_pay_t             r_pay;
  logic                            p_vld;
  logic [eig_pkg::NormRadW-1:0]    p_sum_min;
  logic [eig_pkg::NormRadW-1:0]    p_sum_max;
  eig_pkg::kappa_t                 p_kap;
  eig_pkg::vec_side_t              p_side_min;
  eig_pkg::vec_side_t              p_side_max;
  eig_pkg::min_pay_t               p_min_pay;
  logic                            ln_vld;
  logic                            lx_vld;
  logic [eig_pkg::LenW-1:0]        len_min;
  logic [eig_pkg::LenW-1:0]        len_max;
  logic [MinPW-1:0]                ln_pay_bits;
  logic [SidePW-1:0]               lx_pay_bits;
  eig_pkg::min_pay_t               ln_pay;
  eig_pkg::vec_side_t              lx_pay;
  logic                            l_vld;
  eig_pkg::div_xl_pay_t            xl_in;
  eig_pkg::div_xh_pay_t            xh_in;
  logic [XlPW-1:0]                 xl_out_bits;
  logic [XhPW-1:0]                 xh_out_bits;
  eig_pkg::div_xl_pay_t            xl_out;
  eig_pkg::div_xh_pay_t            xh_out;
  logic                            yl_out;
  logic                            yh_out;
  logic                            dxl_vld;
  logic                            dyl_vld;
  logic                            dxh_vld;
  logic                            dyh_vld;
  logic [eig_pkg::QuotW-1:0]       q_xl;
  logic [eig_pkg::QuotW-1:0]       q_yl;
  logic [eig_pkg::QuotW-1:0]       q_xh;
  logic [eig_pkg::QuotW-1:0]       q_yh;
  logic                            d_vld;

  // every stage moves unless a finished beat is held at the output
  assign en        = !eig_valid || !eig_stall;
  assign mat_stall = !en;

  eig_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (mat_valid),
    .a       (diag_a),
    .b       (off_b),
    .c       (diag_c),
    .out_vld (f_vld),
    .out_rad (f_rad),
    .out_pay (f_pay)
  );

  eig_sqrt_pipe #(
    .RW (eig_pkg::RootRadW),
    .PW ($bits(eig_pkg::front_pay_t))
  ) u_root (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .in_rad   (f_rad),
    .in_pay   (f_pay),
    .out_vld  (r_vld),
    .out_root (r_root),
    .out_pay  (r_pay_bits)
  );

  assign r_pay = r_pay_bits;

  eig_vprep u_vprep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (r_vld),
    .root     (r_root),
    .in_pay   (r_pay),
    .out_vld  (p_vld),
    .sum_min  (p_sum_min),
    .sum_max  (p_sum_max),
    .kap      (p_kap),
    .side_min (p_side_min),
    .side_max (p_side_max)
  );

  assign p_min_pay = '{kap: p_kap, side: p_side_min};

  eig_sqrt_pipe #(
    .RW (eig_pkg::NormRadW),
    .PW (MinPW)
  ) u_len_min (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (p_vld),
    .in_rad   (p_sum_min),
    .in_pay   (p_min_pay),
    .out_vld  (ln_vld),
    .out_root (len_min),
    .out_pay  (ln_pay_bits)
  );

  eig_sqrt_pipe #(
    .RW (eig_pkg::NormRadW),
    .PW (SidePW)
  ) u_len_max (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (p_vld),
    .in_rad   (p_sum_max),
    .in_pay   (p_side_max),
    .out_vld  (lx_vld),
    .out_root (len_max),
    .out_pay  (lx_pay_bits)
  );

  assign ln_pay = ln_pay_bits;
  assign lx_pay = lx_pay_bits;
  assign l_vld  = ln_vld && lx_vld;
  assign xl_in  = '{kap: ln_pay.kap, tiny: ln_pay.side.tiny, neg: ln_pay.side.neg_x};
  assign xh_in  = '{tiny: lx_pay.tiny, neg: lx_pay.neg_x};

  eig_div_pipe #(
    .MW (eig_pkg::MagW),
    .DW (eig_pkg::LenW),
    .QW (eig_pkg::QuotW),
    .FB (eig_pkg::FracBits),
    .PW (XlPW)
  ) u_div_xl (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (l_vld),
    .mag     (ln_pay.side.mag_x),
    .len     (len_min),
    .in_pay  (xl_in),
    .out_vld (dxl_vld),
    .quot    (q_xl),
    .out_pay (xl_out_bits)
  );

  eig_div_pipe #(
    .MW (eig_pkg::MagW),
    .DW (eig_pkg::LenW),
    .QW (eig_pkg::QuotW),
    .FB (eig_pkg::FracBits),
    .PW (1)
  ) u_div_yl (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (l_vld),
    .mag     (ln_pay.side.mag_y),
    .len     (len_min),
    .in_pay  (ln_pay.side.neg_y),
    .out_vld (dyl_vld),
    .quot    (q_yl),
    .out_pay (yl_out)
  );

  eig_div_pipe #(
    .MW (eig_pkg::MagW),
    .DW (eig_pkg::LenW),
    .QW (eig_pkg::QuotW),
    .FB (eig_pkg::FracBits),
    .PW (XhPW)
  ) u_div_xh (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (l_vld),
    .mag     (lx_pay.mag_x),
    .len     (len_max),
    .in_pay  (xh_in),
    .out_vld (dxh_vld),
    .quot    (q_xh),
    .out_pay (xh_out_bits)
  );

  eig_div_pipe #(
    .MW (eig_pkg::MagW),
    .DW (eig_pkg::LenW),
    .QW (eig_pkg::QuotW),
    .FB (eig_pkg::FracBits),
    .PW (1)
  ) u_div_yh (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (l_vld),
    .mag     (lx_pay.mag_y),
    .len     (len_max),
    .in_pay  (lx_pay.neg_y),
    .out_vld (dyh_vld),
    .quot    (q_yh),
    .out_pay (yh_out)
  );

  assign xl_out = xl_out_bits;
  assign xh_out = xh_out_bits;
  assign d_vld  = dxl_vld && dyl_vld && dxh_vld && dyh_vld;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      eig_valid <= 1'b0;
    end else if (en) begin
      eig_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kappa_min <= xl_out.kap.kmin;
      kappa_max <= xl_out.kap.kmax;
      vec_min_x <= eig_pkg::unit_out(q_xl, xl_out.neg, xl_out.tiny);
      vec_min_y <= eig_pkg::unit_out(q_yl, yl_out, xl_out.tiny);
      vec_max_x <= eig_pkg::unit_out(q_xh, xh_out.neg, xh_out.tiny);
      vec_max_y <= eig_pkg::unit_out(q_yh, yh_out, xh_out.tiny);
    end
  end

  // eigenvalues come out ordered, saturation keeps the order
  a_kappa_order: assert property (@(posedge clk) disable iff (rst)
    eig_valid |-> (kappa_min <= kappa_max))
    else $error("smaller eigenvalue above larger one");

  a_vec_min_range: assert property (@(posedge clk) disable iff (rst)
    eig_valid |-> (vec_min_x != 16'sh8000) && (vec_min_y != 16'sh8000))
    else $error("min eigenvector component out of q1.15 range");

  a_vec_max_range: assert property (@(posedge clk) disable iff (rst)
    eig_valid |-> (vec_max_x != 16'sh8000) && (vec_max_y != 16'sh8000))
    else $error("max eigenvector component out of q1.15 range");

endmodule

`default_nettype wire

// ===== test/symmetric_2x2_eigen_solver_chk.sv =====
// checker for symmetric_2x2_eigen_solver: predicts each eigen beat from the matrix beat
// and compares in order; depends on eig_pkg for widths only
`default_nettype none

module symmetric_2x2_eigen_solver_chk (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             mat_valid,
  input  logic                             mat_stall,
  input  logic signed [eig_pkg::DataW-1:0] diag_a,
  input  logic signed [eig_pkg::DataW-1:0] off_b,
  input  logic signed [eig_pkg::DataW-1:0] diag_c,
  input  logic                             eig_valid,
  input  logic                             eig_stall,
  input  logic signed [eig_pkg::DataW-1:0] kappa_min,
  input  logic signed [eig_pkg::DataW-1:0] kappa_max,
  input  logic signed [eig_pkg::UnitW-1:0] vec_min_x,
  input  logic signed [eig_pkg::UnitW-1:0] vec_min_y,
  input  logic signed [eig_pkg::UnitW-1:0] vec_max_x,
  input  logic signed [eig_pkg::UnitW-1:0] vec_max_y,
  output int                               errors,
  output int                               pending
);

  typedef struct packed {
    logic [31:0] kmin;
    logic [31:0] kmax;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] xx;
    logic [15:0] xy;
  } eigen_t;

  localparam int ExpDepth = 256;

  // expected beats in a ring, far deeper than the pipeline
  eigen_t exp_mem [ExpDepth];
  int     wr_cnt = 0;
  int     rd_cnt = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] half_sat(input longint v);
    longint h;
    h = v >>> 1;
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    return h[31:0];
  endfunction

  function automatic logic [15:0] unit_part(input logic [63:0] m, input bit ng,
                                            input logic [63:0] len);
    logic [63:0] q;
    q = (m * 32768 + len / 2) / len;
    if (q > 32767) q = 32767;
    return ng ? 16'(-q) : q[15:0];
  endfunction

  function automatic logic [31:0] unit_vec(input longint x, input longint y);
    bit nx, ny;
    logic [63:0] ux, uy, len;
    nx = x < 0;
    ny = y < 0;
    ux = nx ? -x : x;
    uy = ny ? -y : y;
    if (ux <= 2 && uy <= 2 && ux * ux + uy * uy <= 4) return 32'd0;
    while (ux >= 64'd1 << 31 || uy >= 64'd1 << 31) begin
      ux = ux >> 1;
      uy = uy >> 1;
    end
    len = int_sqrt(ux * ux + uy * uy);
    if (len == 0) len = 1;
    return {unit_part(ux, nx, len), unit_part(uy, ny, len)};
  endfunction

  function automatic eigen_t solve_eigen(input longint a, input longint b, input longint c);
    longint s, d, p, q, rr;
    logic [63:0] y, r0, r;
    logic [31:0] vn, vx;
    eigen_t e;
    s = a + c;
    d = a - c;
    p = d & 1;
    q = (d - p) / 2;
    y = 64'(q * q + q * p) + 64'(b * b);
    r0 = int_sqrt(y);
    r = 2 * r0;
    // d*d + 4b*b = 4y + p, pick the last root bit
    if (p != 0 ? (r0 * r0 + r0 <= y) : (r0 * r0 + r0 < y)) r = r + 1;
    rr = longint'(r);
    vn = unit_vec(2 * b, -d - rr);
    vx = unit_vec(2 * b, -d + rr);
    e.kmin = half_sat(s - rr);
    e.kmax = half_sat(s + rr);
    {e.nx, e.ny} = vn;
    {e.xx, e.xy} = vx;
    return e;
  endfunction

  assign pending = wr_cnt - rd_cnt;

  always @(posedge clk) begin
    eigen_t exp_e, got;
    if (rst) begin
      errors <= 0;
      wr_cnt <= 0;
      rd_cnt <= 0;
    end else begin
      if (mat_valid && !mat_stall) begin
        exp_mem[wr_cnt % ExpDepth] <= solve_eigen(longint'(diag_a), longint'(off_b),
                                                  longint'(diag_c));
        wr_cnt <= wr_cnt + 1;
      end
      if (eig_valid && !eig_stall) begin
        got = {kappa_min, kappa_max, vec_min_x, vec_min_y, vec_max_x, vec_max_y};
        if (wr_cnt == rd_cnt) begin
          $display("%0t: unexpected beat %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_e = exp_mem[rd_cnt % ExpDepth];
          rd_cnt <= rd_cnt + 1;
          if (exp_e !== got) begin
            $display("%0t: mismatch expected kmin %h kmax %h min %h %h max %h %h", $time,
                     exp_e.kmin, exp_e.kmax, exp_e.nx, exp_e.ny, exp_e.xx, exp_e.xy);
            $display("%0t:            actual kmin %h kmax %h min %h %h max %h %h", $time,
                     got.kmin, got.kmax, got.nx, got.ny, got.xx, got.xy);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/symmetric_2x2_eigen_solver_tb.sv =====
// top of the symmetric_2x2_eigen_solver test: matrix stimulus, eigen stall pattern,
// watchdog and verdict; depends on the dut and symmetric_2x2_eigen_solver_chk
`default_nettype none

module symmetric_2x2_eigen_solver_tb;

  logic clk;
  logic rst = 1'b1;
  logic mat_valid = 1'b0;
  logic eig_stall = 1'b0;
  logic signed [31:0] diag_a = '0, off_b = '0, diag_c = '0;
  logic mat_stall, eig_valid;
  logic signed [31:0] kappa_min, kappa_max;
  logic signed [15:0] vec_min_x, vec_min_y, vec_max_x, vec_max_y;
  int errors, pending;
  int idle_pct = 30;
  bit hold_rx = 0;
  int quiet = 0;

  symmetric_2x2_eigen_solver dut (.*);
  symmetric_2x2_eigen_solver_chk chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] pick_entry();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 4) - 2;
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3) : 32'h8000_0000;
      4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_matrix(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    while ($urandom_range(0, 99) < idle_pct) begin
      mat_valid <= 1'b0;
      @(posedge clk);
    end
    mat_valid <= 1'b1;
    diag_a <= a;
    off_b <= b;
    diag_c <= c;
    @(posedge clk);
    while (mat_stall) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) eig_stall <= 1'b0;
    else eig_stall <= hold_rx || ($urandom_range(0, 99) < idle_pct);
  end

  // watchdog on cycles with no accepted beat, paused while the receiver is held off
  always @(posedge clk) begin
    if ((mat_valid && !mat_stall) || (eig_valid && !eig_stall) || hold_rx) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] corner[6];
    int i, j, k;
    corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes, zero off-diagonal, equal diagonals
    for (i = 0; i < 6; i++) send_matrix(corner[i], 32'h0, corner[(i + 2) % 6]);
    send_matrix(32'h0, 32'h0, 32'h0);
    send_matrix(32'h0003_0000, 32'h0, 32'h0003_0000);
    send_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(32'h1, 32'h1, 32'h0);
    send_matrix(32'h0, 32'hFFFF_FFFF, 32'h0);
    send_matrix(32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
    for (i = 0; i < 6; i++) send_matrix(corner[i], corner[5 - i], corner[(i + 3) % 6]);
    // sender pauses until the pipe drains
    mat_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // receiver holds off while the sender keeps going
    hold_rx = 1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_rx = 0;
      end
      for (j = 0; j < 200; j++) send_matrix(pick_entry(), pick_entry(), pick_entry());
    join
    // stretch with no idling
    idle_pct = 0;
    for (j = 0; j < 300; j++) send_matrix(pick_entry(), pick_entry(), pick_entry());
    idle_pct = 30;
    for (k = 0; k < 1250; k++) send_matrix(pick_entry(), pick_entry(), pick_entry());
    mat_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/eig_pkg.sv
design/eig_front.sv
design/eig_sqrt_pipe.sv
design/eig_vprep.sv
design/eig_div_pipe.sv
design/symmetric_2x2_eigen_solver.sv
test/symmetric_2x2_eigen_solver_chk.sv
test/symmetric_2x2_eigen_solver_tb.sv
